// File: src/stc_pkg.sv
// Shared types and codes for the slot table.
`timescale 1ns / 1ps
package stc_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_LOOKUP  = 2'd2,
    CMD_COMPACT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] key_object;
    logic signed [31:0] key_touch;
    logic [31:0]        new_payload;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_object;
    logic [7:0]         slot_used;
    logic [8:0]         used_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_HI_RD,
    S_HI_CHK,
    S_LO_RD,
    S_LO_CHK,
    S_MOVE,
    S_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture request, reset scan pointers
    logic rd_k;      // read entry at scan pointer k
    logic rd_hi;     // read entry at hi-1
    logic rd_lo;     // read entry at lo
    logic inc_k;
    logic dec_hi;
    logic inc_lo;
    logic wr_ins;    // insert write at k
    logic wr_kill;   // mark entry k dead
    logic mv_lo;     // write saved hi entry into lo
    logic hit;       // record lookup hit at k
    logic full;
    logic set_cnt_hi;
    logic set_cnt_top; // count = hi+1, the held live entry stays at hi
    logic fin;       // emit result
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       k_end;     // k reached count
    logic       k_cap;     // count at capacity
    logic       rd_dead;
    logic       obj_eq;
    logic       tch_eq;
    logic       tch_neg;
    logic       lo_ge_hi;
  } sts_t;

endpackage

// File: src/stc_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module stc_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: src/stc_datapath.sv
// Slot table storage, scan pointers and result register.
`timescale 1ns / 1ps
module stc_datapath #(
  parameter int Capacity = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  stc_pkg::req_t req,
  input  stc_pkg::ctl_t ctl,
  output stc_pkg::sts_t sts,
  output stc_pkg::rsp_t rsp
);
  import stc_pkg::*;

  localparam int AW = $clog2(Capacity);
  localparam int CW = $clog2(Capacity + 1);
  localparam int EW = 97;

  req_t          rq;
  logic [CW-1:0] count, k, lo, hi;
  logic [EW-1:0] saved;
  logic          we;
  logic [AW-1:0] addr;
  logic [EW-1:0] wdata, rdata;
  logic [1:0]    status;
  logic [31:0]   found;
  logic [CW-1:0] slot;

  always_comb begin
    we    = ctl.wr_ins | ctl.wr_kill | ctl.mv_lo;
    addr  = k[AW-1:0];
    wdata = {1'b0, rq.key_object, rq.key_touch, rq.new_payload};
    if (ctl.rd_hi) addr = AW'(hi - CW'(1));
    if (ctl.rd_lo || ctl.mv_lo) addr = lo[AW-1:0];
    if (ctl.wr_kill) wdata = {1'b1, rdata[95:0]};
    if (ctl.mv_lo) wdata = {1'b0, saved[95:0]};
  end

  stc_ram #(.Width(EW), .Depth(Capacity)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (ctl.wr_ins && k == count) count <= count + CW'(1);
      if (ctl.set_cnt_hi) count <= hi;
      if (ctl.set_cnt_top) count <= hi + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rq     <= req;
      k      <= '0;
      lo     <= '0;
      hi     <= count;
      status <= ST_DONE;
      found  <= '0;
      slot   <= '0;
    end
    if (ctl.inc_k) k <= k + CW'(1);
    if (ctl.inc_lo) lo <= lo + CW'(1);
    if (ctl.dec_hi) hi <= hi - CW'(1);
    if (ctl.rd_hi) saved <= '0;
    if (ctl.dec_hi && !rdata[96]) saved <= rdata;
    if (ctl.wr_ins) slot <= k;
    if (ctl.full) status <= ST_FULL;
    if (ctl.hit) begin
      found <= rdata[95:64];
      slot  <= k;
    end
    if (ctl.fin && rq.cmd == CMD_LOOKUP && found == '0 && slot == '0
        && status == ST_DONE && !ctl.hit) begin
      status <= ST_DONE;
    end
  end

  // set once a lookup has matched an entry
  logic hit_seen;
  always_ff @(posedge clk) begin
    if (ctl.load) hit_seen <= 1'b0;
    if (ctl.hit) hit_seen <= 1'b1;
  end

  always_comb begin
    sts.cmd      = rq.cmd;
    sts.k_end    = (k == count);
    sts.k_cap    = (count == CW'(Capacity));
    sts.rd_dead  = rdata[96];
    sts.obj_eq   = (rdata[95:64] == rq.key_object);
    sts.tch_eq   = (rdata[63:32] == rq.key_touch);
    sts.tch_neg  = rq.key_touch[31];
    sts.lo_ge_hi = (lo >= hi);
  end

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      rsp.status       <= (rq.cmd == CMD_LOOKUP && !hit_seen) ? ST_NOTFOUND : status;
      rsp.found_object <= found;
      rsp.slot_used    <= 8'(slot);
      rsp.used_count   <= 9'(count);
    end
  end
endmodule

// File: src/stc_ctrl.sv
// Command sequencer for the slot table.
`timescale 1ns / 1ps
module stc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  input  stc_pkg::sts_t sts,
  output stc_pkg::ctl_t ctl
);
  import stc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_SCAN_RD;
      S_SCAN_RD: begin
        if (sts.cmd == CMD_COMPACT) state_next = S_HI_RD;
        else if (sts.k_end) state_next = S_DONE;
        else if (sts.cmd == CMD_LOOKUP && sts.tch_neg) state_next = S_DONE;
        else state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.cmd == CMD_INSERT && sts.rd_dead) state_next = S_DONE;
        else if (sts.cmd == CMD_LOOKUP && sts.tch_eq) state_next = S_DONE;
        else state_next = S_SCAN_RD;
      end
      S_HI_RD:  state_next = sts.lo_ge_hi ? S_DONE : S_HI_CHK;
      S_HI_CHK: state_next = sts.rd_dead ? S_HI_RD : S_LO_RD;
      S_LO_RD:  state_next = sts.lo_ge_hi ? S_DONE : S_LO_CHK;
      S_LO_CHK: state_next = sts.rd_dead ? S_MOVE : S_LO_RD;
      S_MOVE:   state_next = S_HI_RD;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = (state != S_IDLE);
    done = 1'b0;
    unique case (state)
      S_IDLE: ctl.load = start;
      S_SCAN_RD: begin
        ctl.rd_k = 1'b1;
        if (sts.cmd == CMD_INSERT && sts.k_end) begin
          if (sts.k_cap) ctl.full = 1'b1;
          else ctl.wr_ins = 1'b1;
        end
      end
      S_SCAN_CHK: begin
        ctl.rd_k = 1'b1;
        if (sts.cmd == CMD_INSERT && sts.rd_dead) ctl.wr_ins = 1'b1;
        else if (sts.cmd == CMD_LOOKUP && sts.tch_eq) ctl.hit = 1'b1;
        else begin
          if (sts.cmd == CMD_DELETE && sts.obj_eq) ctl.wr_kill = 1'b1;
          ctl.inc_k = 1'b1;
        end
      end
      S_HI_RD: begin
        ctl.rd_hi = 1'b1;
        if (sts.lo_ge_hi) ctl.set_cnt_hi = 1'b1;
      end
      S_HI_CHK: begin
        ctl.dec_hi = 1'b1;
      end
      S_LO_RD: begin
        ctl.rd_lo = 1'b1;
        // no hole below the held live entry: it stays in place
        if (sts.lo_ge_hi) ctl.set_cnt_top = 1'b1;
      end
      S_LO_CHK: begin
        ctl.rd_lo = 1'b1;
        if (!sts.rd_dead) ctl.inc_lo = 1'b1;
      end
      S_MOVE: begin
        ctl.mv_lo  = 1'b1;
        ctl.inc_lo = 1'b1;
      end
      S_DONE: begin
        ctl.fin = 1'b1;
        done    = 1'b1;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after result");
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("start not taken");
  assert property (@(posedge clk) disable iff (rst) !(ctl.wr_ins && ctl.mv_lo))
    else $error("write conflict");
endmodule

// File: src/slot_table_reuse_compact.sv
// Slot table with tombstone reuse and compaction, top level.
// Insert, delete and lookup scan the slots in order from the bottom, up to CAPACITY of them;
// compact moves live entries down from the top into dead slots.
// One command at a time: busy is high from the transfer until the result strobe.
// The result is shown for one cycle with valid; the receiver cannot stall.
// Synchronous reset empties the table (count zero); storage is not cleared.
`timescale 1ns / 1ps
module slot_table_reuse_compact #(
  parameter int CAPACITY = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  stc_pkg::req_t req,
  output logic          busy,
  output logic          valid,
  output stc_pkg::rsp_t rsp
);
  import stc_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic done;

  stc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .sts(sts), .ctl(ctl)
  );

  stc_datapath #(.Capacity(CAPACITY)) u_dp (
    .clk(clk), .rst(rst), .req(req), .ctl(ctl), .sts(sts), .rsp(rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else     valid <= done;
  end
endmodule
